// ----- hw/rtl/skpl_pkg.sv -----
// Shared types, constants and the control store for the stereo soft-knee limiter.
// Used by skpl_cfg_regs, skpl_sequencer, skpl_datapath and the top level.
// Depends on nothing else.
package skpl_pkg;

  // Sample width and derived datapath widths.
  localparam int SAMPLE_BITS = 24;
  localparam int MUL_A_W     = ((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24) + 1;
  localparam int MUL_B_W     = 25;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  // Q1.23 constants.
  localparam logic [23:0] UNITY    = 24'h800000;
  localparam logic [23:0] HALF_LSB = 24'h400000;

  // Restoring divider: one quotient bit per step.
  localparam int DIV_STEPS = 23;
  localparam int LCNT_W    = $clog2(DIV_STEPS);

  // Register file addressing.
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_CEILING   = 3'd0;
  localparam logic [2:0] REG_KNEE_LOW  = 3'd1;
  localparam logic [2:0] REG_KNEE_HIGH = 3'd2;
  localparam logic [2:0] REG_SPAN_RCP  = 3'd3;
  localparam logic [2:0] REG_END_GAIN  = 3'd4;
  localparam logic [2:0] REG_RELEASE   = 3'd5;
  localparam logic [2:0] REG_SMOOTH    = 3'd6;

  // Request payloads.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_end_in;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_limited;
    logic signed [SAMPLE_BITS-1:0] right_limited;
    logic [23:0]                   applied_gain;
    logic                          block_end_out;
  } result_t;

  // Configuration register set.
  typedef struct packed {
    logic [23:0] ceiling_level;
    logic [23:0] knee_low_level;
    logic [23:0] knee_high_level;
    logic [23:0] knee_span_recip;
    logic [23:0] knee_end_gain;
    logic [23:0] decay_coeff;
    logic [23:0] smooth_coeff;
  } cfg_t;

  // Datapath operations, one per control word.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_REL,
    OP_ENV_UPD,
    OP_TG_UNITY,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_MUL_T,
    OP_T_SAT,
    OP_MUL_TT,
    OP_T2,
    OP_MUL_DROP,
    OP_TG_KNEE,
    OP_MUL_SMOOTH,
    OP_GAIN_UPD,
    OP_MUL_L,
    OP_SCALE_L,
    OP_MUL_R,
    OP_SCALE_R,
    OP_EMIT
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_ENV_LOW,
    COND_IN_KNEE,
    COND_DIV_MORE,
    COND_OUT_HOLD
  } cond_t;

  // Step counter and step addresses.
  localparam int UPC_W = 5;
  localparam logic [UPC_W-1:0] S_IDLE     = 5'd0;
  localparam logic [UPC_W-1:0] S_REL      = 5'd1;
  localparam logic [UPC_W-1:0] S_ENV      = 5'd2;
  localparam logic [UPC_W-1:0] S_LOW      = 5'd3;
  localparam logic [UPC_W-1:0] S_DIV_INIT = 5'd4;
  localparam logic [UPC_W-1:0] S_DIV      = 5'd5;
  localparam logic [UPC_W-1:0] S_DIV_DONE = 5'd6;
  localparam logic [UPC_W-1:0] S_KNEE     = 5'd7;
  localparam logic [UPC_W-1:0] S_T_SAT    = 5'd8;
  localparam logic [UPC_W-1:0] S_TT       = 5'd9;
  localparam logic [UPC_W-1:0] S_T2       = 5'd10;
  localparam logic [UPC_W-1:0] S_DROP     = 5'd11;
  localparam logic [UPC_W-1:0] S_TG_KNEE  = 5'd12;
  localparam logic [UPC_W-1:0] S_SMOOTH   = 5'd13;
  localparam logic [UPC_W-1:0] S_GAIN     = 5'd14;
  localparam logic [UPC_W-1:0] S_MUL_L    = 5'd15;
  localparam logic [UPC_W-1:0] S_SCALE_L  = 5'd16;
  localparam logic [UPC_W-1:0] S_MUL_R    = 5'd17;
  localparam logic [UPC_W-1:0] S_SCALE_R  = 5'd18;
  localparam logic [UPC_W-1:0] S_EMIT     = 5'd19;
  localparam logic [UPC_W-1:0] S_RET      = 5'd20;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic req;
    logic env_low;
    logic in_knee;
    logic div_more;
    logic out_hold;
  } seq_status_t;

  // Clamp a Q1.23 value to unity.
  function automatic logic [23:0] sat24(input logic [23:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  // Control store: the whole per-request program.
  function automatic uword_t ucode_word(input logic [UPC_W-1:0] upc);
    uword_t w;
    case (upc)
      S_IDLE:     w = '{OP_LOAD,       COND_NO_REQ,   S_IDLE};
      S_REL:      w = '{OP_MUL_REL,    COND_NONE,     S_IDLE};
      S_ENV:      w = '{OP_ENV_UPD,    COND_NONE,     S_IDLE};
      S_LOW:      w = '{OP_TG_UNITY,   COND_ENV_LOW,  S_SMOOTH};
      S_DIV_INIT: w = '{OP_DIV_INIT,   COND_IN_KNEE,  S_KNEE};
      S_DIV:      w = '{OP_DIV_STEP,   COND_DIV_MORE, S_DIV};
      S_DIV_DONE: w = '{OP_DIV_DONE,   COND_ALWAYS,   S_SMOOTH};
      S_KNEE:     w = '{OP_MUL_T,      COND_NONE,     S_IDLE};
      S_T_SAT:    w = '{OP_T_SAT,      COND_NONE,     S_IDLE};
      S_TT:       w = '{OP_MUL_TT,     COND_NONE,     S_IDLE};
      S_T2:       w = '{OP_T2,         COND_NONE,     S_IDLE};
      S_DROP:     w = '{OP_MUL_DROP,   COND_NONE,     S_IDLE};
      S_TG_KNEE:  w = '{OP_TG_KNEE,    COND_NONE,     S_IDLE};
      S_SMOOTH:   w = '{OP_MUL_SMOOTH, COND_NONE,     S_IDLE};
      S_GAIN:     w = '{OP_GAIN_UPD,   COND_NONE,     S_IDLE};
      S_MUL_L:    w = '{OP_MUL_L,      COND_NONE,     S_IDLE};
      S_SCALE_L:  w = '{OP_SCALE_L,    COND_NONE,     S_IDLE};
      S_MUL_R:    w = '{OP_MUL_R,      COND_NONE,     S_IDLE};
      S_SCALE_R:  w = '{OP_SCALE_R,    COND_NONE,     S_IDLE};
      S_EMIT:     w = '{OP_EMIT,       COND_OUT_HOLD, S_EMIT};
      S_RET:      w = '{OP_NOP,        COND_ALWAYS,   S_IDLE};
      default:    w = '{OP_NOP,        COND_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/skpl_cfg_regs.sv -----
// APB-style register file holding the limiter settings.
// Depends on skpl_pkg for the register indexes and the cfg_t bundle.
module skpl_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skpl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output skpl_pkg::cfg_t              cfg
);
  import skpl_pkg::*;

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; reset loads the default settings.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ceiling_level   <= 24'd6290573;
      cfg.knee_low_level  <= 24'd5292851;
      cfg.knee_high_level <= 24'd7476319;
      cfg.knee_span_recip <= 24'd251777;
      cfg.knee_end_gain   <= 24'd7058083;
      cfg.decay_coeff     <= 24'd8371152;
      cfg.smooth_coeff    <= 24'd8353729;
    end else if (wr_en) begin
      case (idx)
        REG_CEILING:   cfg.ceiling_level   <= pwdata[23:0];
        REG_KNEE_LOW:  cfg.knee_low_level  <= pwdata[23:0];
        REG_KNEE_HIGH: cfg.knee_high_level <= pwdata[23:0];
        REG_SPAN_RCP:  cfg.knee_span_recip <= pwdata[23:0];
        REG_END_GAIN:  cfg.knee_end_gain   <= pwdata[23:0];
        REG_RELEASE:   cfg.decay_coeff     <= pwdata[23:0];
        REG_SMOOTH:    cfg.smooth_coeff    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read mux; unused addresses read as zero.
  always_comb begin
    case (idx)
      REG_CEILING:   prdata = {8'd0, cfg.ceiling_level};
      REG_KNEE_LOW:  prdata = {8'd0, cfg.knee_low_level};
      REG_KNEE_HIGH: prdata = {8'd0, cfg.knee_high_level};
      REG_SPAN_RCP:  prdata = {8'd0, cfg.knee_span_recip};
      REG_END_GAIN:  prdata = {8'd0, cfg.knee_end_gain};
      REG_RELEASE:   prdata = {8'd0, cfg.decay_coeff};
      REG_SMOOTH:    prdata = {8'd0, cfg.smooth_coeff};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/skpl_sequencer.sv -----
// Step counter and control store lookup for the limiter program.
// Depends on skpl_pkg for the control word, conditions and step addresses.
module skpl_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  skpl_pkg::seq_status_t status,
  output skpl_pkg::uword_t      ctrl
);
  import skpl_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             take;

  assign ctrl = ucode_word(upc);

  // Evaluate the jump condition of the current step.
  always_comb begin
    case (ctrl.cond)
      COND_NONE:     take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_REQ:   take = !status.req;
      COND_ENV_LOW:  take = status.env_low;
      COND_IN_KNEE:  take = status.in_knee;
      COND_DIV_MORE: take = status.div_more;
      COND_OUT_HOLD: take = status.out_hold;
      default:       take = 1'b0;
    endcase
  end

  assign upc_next = take ? ctrl.target : upc + UPC_W'(1);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // The program stays in its entry step until a request arrives.
  a_idle_waits: assert property (@(posedge clk) disable iff (rst)
    (upc == S_IDLE && !status.req) |=> upc == S_IDLE)
    else $error("sequencer left idle without a request");

  // The counter never runs past the last step of the program.
  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    upc <= S_RET)
    else $error("step counter out of program range");

endmodule

// ----- hw/rtl/skpl_datapath.sv -----
// Limiter datapath: envelope and gain state, one shared multiplier, a restoring
// divider step and the result register. Driven by control words from
// skpl_sequencer; depends on skpl_pkg.
module skpl_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  skpl_pkg::uword_t      ctrl,
  input  skpl_pkg::cfg_t        cfg,
  input  logic                  sample_valid,
  input  skpl_pkg::sample_t     sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output skpl_pkg::result_t     result,
  output skpl_pkg::seq_status_t status
);
  import skpl_pkg::*;

  // Request registers.
  logic signed [SAMPLE_BITS-1:0] samp_l;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic                          blk;
  logic [23:0]                   pk;

  // Persistent state and working registers.
  logic [23:0]             env;
  logic [23:0]             gain;
  logic [23:0]             tg;
  logic [23:0]             tmp;
  logic [23:0]             rem;
  logic [22:0]             quot;
  logic [LCNT_W-1:0]       lcnt;
  logic signed [PROD_W-1:0] acc;
  logic signed [SAMPLE_BITS-1:0] lout;
  logic signed [SAMPLE_BITS-1:0] rout;

  // Peak of the incoming pair, scaled to Q1.23.
  logic [SAMPLE_BITS-1:0]  mag_l;
  logic [SAMPLE_BITS-1:0]  mag_r;
  logic [SAMPLE_BITS-1:0]  mag_max;
  logic [SAMPLE_BITS+23:0] mag_wide;
  logic [23:0]             pk_in;

  assign mag_l    = sample.left_sample[SAMPLE_BITS-1] ?
                    (~$unsigned(sample.left_sample) + 1'b1) : $unsigned(sample.left_sample);
  assign mag_r    = sample.right_sample[SAMPLE_BITS-1] ?
                    (~$unsigned(sample.right_sample) + 1'b1) : $unsigned(sample.right_sample);
  assign mag_max  = (mag_l > mag_r) ? mag_l : mag_r;
  assign mag_wide = {mag_max, 24'd0} >> SAMPLE_BITS;
  assign pk_in    = mag_wide[23:0];

  // Shared multiplier operand selection.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  logic [23:0]               gain_diff;

  assign gain_diff = (tg >= gain) ? (tg - gain) : (gain - tg);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (ctrl.op)
      OP_MUL_REL: begin
        mul_a = signed'(MUL_A_W'(UNITY - sat24(cfg.decay_coeff)));
        mul_b = signed'(MUL_B_W'(env - pk));
      end
      OP_MUL_T: begin
        mul_a = signed'(MUL_A_W'(env - cfg.knee_low_level));
        mul_b = signed'(MUL_B_W'(cfg.knee_span_recip));
      end
      OP_MUL_TT: begin
        mul_a = signed'(MUL_A_W'(tmp));
        mul_b = signed'(MUL_B_W'(tmp));
      end
      OP_MUL_DROP: begin
        mul_a = signed'(MUL_A_W'(UNITY - sat24(cfg.knee_end_gain)));
        mul_b = signed'(MUL_B_W'(tmp));
      end
      OP_MUL_SMOOTH: begin
        mul_a = signed'(MUL_A_W'(UNITY - sat24(cfg.smooth_coeff)));
        mul_b = signed'(MUL_B_W'(gain_diff));
      end
      OP_MUL_L: begin
        mul_a = MUL_A_W'(samp_l);
        mul_b = signed'(MUL_B_W'(gain));
      end
      OP_MUL_R: begin
        mul_a = MUL_A_W'(samp_r);
        mul_b = signed'(MUL_B_W'(gain));
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Rounded and saturated views of the product register.
  logic [PROD_W-1:0] rnd;
  logic [23:0]       rnd_q23;
  logic [31:0]       t_raw;
  logic [23:0]       t_sat;

  assign rnd     = $unsigned(acc) + PROD_W'(HALF_LSB);
  assign rnd_q23 = rnd[46:23];
  assign t_raw   = acc[47:16];
  assign t_sat   = (t_raw > 32'(UNITY)) ? UNITY : t_raw[23:0];

  // Divider step: shift the partial remainder and subtract when it fits.
  logic [24:0] rem_sh;
  logic        q_bit;

  assign rem_sh = {rem, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, env});

  // Gain update, rounded move toward the target.
  logic [24:0] gain_up;
  logic [23:0] gain_new;

  assign gain_up  = {1'b0, gain} + {1'b0, rnd_q23};
  assign gain_new = (tg >= gain) ?
                    ((gain_up > {1'b0, UNITY}) ? UNITY : gain_up[23:0]) :
                    (gain - rnd_q23);

  // Status for the sequencer.
  logic out_hold;

  assign out_hold        = result_valid && result_stall;
  assign status.req      = sample_valid;
  assign status.env_low  = (env <= cfg.knee_low_level);
  assign status.in_knee  = (env < cfg.knee_high_level);
  assign status.div_more = (lcnt != LCNT_W'(DIV_STEPS - 1));
  assign status.out_hold = out_hold;

  // Product register.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      acc <= mul_a * mul_b;
    end
  end

  // State with reset values: envelope, kept gain and the result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      env          <= 24'd0;
      gain         <= UNITY;
      result_valid <= 1'b0;
    end else begin
      if (ctrl.op == OP_ENV_UPD) begin
        env <= (pk > env) ? pk : (env - rnd_q23);
      end
      if (ctrl.op == OP_GAIN_UPD) begin
        gain <= gain_new;
      end
      if (ctrl.op == OP_EMIT && !out_hold) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Working registers and payload.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (sample_valid) begin
          samp_l <= sample.left_sample;
          samp_r <= sample.right_sample;
          blk    <= sample.block_end_in;
          pk     <= pk_in;
        end
      end
      OP_TG_UNITY: tg <= UNITY;
      OP_DIV_INIT: begin
        rem  <= cfg.ceiling_level;
        quot <= '0;
        lcnt <= '0;
      end
      OP_DIV_STEP: begin
        rem  <= q_bit ? 24'(rem_sh - {1'b0, env}) : rem_sh[23:0];
        quot <= {quot[21:0], q_bit};
        lcnt <= lcnt + LCNT_W'(1);
      end
      OP_DIV_DONE: tg <= (cfg.ceiling_level >= env) ? UNITY : {1'b0, quot};
      OP_T_SAT:    tmp <= t_sat;
      OP_T2:       tmp <= rnd_q23;
      OP_TG_KNEE:  tg <= UNITY - rnd_q23;
      OP_SCALE_L:  lout <= signed'(rnd[SAMPLE_BITS+22:23]);
      OP_SCALE_R:  rout <= signed'(rnd[SAMPLE_BITS+22:23]);
      OP_EMIT: begin
        if (!out_hold) begin
          result.left_limited  <= lout;
          result.right_limited <= rout;
          result.applied_gain  <= gain;
          result.block_end_out <= blk;
        end
      end
      default: ;
    endcase
  end

  // The kept gain and the envelope never leave the Q1.23 unit range.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (gain <= UNITY) && (env <= UNITY))
    else $error("gain or envelope above unity");

  // An emitted result carries the gain that was in force at the emit step.
  a_emit_gain: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT && !out_hold) |=>
      (result_valid && result.applied_gain == $past(gain)))
    else $error("emitted result lost or carries wrong gain");

endmodule

// ----- hw/rtl/stereo_soft_knee_peak_limiter_top.sv -----
// A request takes the short path below the knee, the knee path in the knee, and
// the 23-step restoring divider in the hard region.
// A new request is taken only once the program has emitted the previous result.
// The result register holds one finished result while the next request is taken.
// Reset (rst, synchronous): envelope zero, gain unity, settings to defaults.
// Depends on skpl_pkg, skpl_cfg_regs, skpl_sequencer and skpl_datapath.
module stereo_soft_knee_peak_limiter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  skpl_pkg::sample_t           sample,
  output logic                        result_valid,
  input  logic                        result_stall,
  output skpl_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skpl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import skpl_pkg::*;

  cfg_t        cfg;
  uword_t      ctrl;
  seq_status_t status;

  // Requests are taken only in the program's entry step.
  assign sample_stall = (ctrl.op != OP_LOAD);

  skpl_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  skpl_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  skpl_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .status       (status)
  );

endmodule
